/* hdl/msat_pkg.sv */
// Shared types and constants for the multi-slot alarm table.
// Used by msat_cell, multi_slot_alarm_table and the testbench; depends on nothing else.
package msat_pkg;

    localparam int SLOTS        = 8;
    localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int FIRED_SLOT_W = 3;
    localparam int IDX_W        = (SLOT_W > FIRED_SLOT_W) ? SLOT_W : FIRED_SLOT_W;
    localparam int EVENT_W      = 8;
    localparam int PERIOD_W     = 23;
    localparam int TIME_W       = 32;

    typedef enum logic {
        OP_SET  = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Item held for the whole walk down the chain
    typedef struct packed {
        op_t                 op;
        logic [EVENT_W-1:0]  event_id;
        logic                periodic;
        logic [PERIOD_W-1:0] delay_ms;
        logic [TIME_W-1:0]   now_ms;
    } item_t;

    // Token handed from cell to cell
    typedef struct packed {
        logic             go;
        logic             matched;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } carry_t;

    // Addressed write of a new alarm
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } ins_t;

    // Expiry report of one cell
    typedef struct packed {
        logic               fire;
        logic [EVENT_W-1:0] event_id;
    } fire_t;

endpackage

/* hdl/msat_cell.sv */
// One alarm slot of the chain: holds the slot state and the token register.
// Depends on msat_pkg.
module msat_cell
    import msat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [IDX_W-1:0] cell_idx,
    input  item_t            item,
    input  logic             hold,
    input  carry_t           carry_in,
    input  ins_t             ins,
    output carry_t           carry_out,
    output fire_t            fire
);

    logic                valid_reg, valid_next;
    logic [EVENT_W-1:0]  event_reg, event_next;
    logic                periodic_reg, periodic_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [TIME_W-1:0]   deadline_reg, deadline_next;
    carry_t              carry_reg, carry_next;

    logic                act;
    logic                hit;
    logic                expired;
    logic                ins_here;
    logic [PERIOD_W-1:0] addend;
    logic [TIME_W-1:0]   sum;

    assign act      = carry_in.go & ~hold;
    assign hit      = valid_reg & (event_reg == item.event_id);
    assign expired  = valid_reg & (item.now_ms >= deadline_reg);
    assign ins_here = ins.en & (ins.idx == cell_idx);

    // Ticks re-arm with the stored period, sets use the item delay
    assign addend = (act && item.op == OP_TICK) ? period_reg : item.delay_ms;
    assign sum    = item.now_ms + TIME_W'(addend);

    assign fire.fire     = carry_in.go & (item.op == OP_TICK) & expired;
    assign fire.event_id = event_reg;

    always_comb
    begin
        valid_next    = valid_reg;
        event_next    = event_reg;
        periodic_next = periodic_reg;
        period_next   = period_reg;
        deadline_next = deadline_reg;
        if (act)
        begin
            case (item.op)
                OP_SET:
                begin
                    if (hit)
                    begin
                        if (item.delay_ms == '0)
                            valid_next = 1'b0;
                        else
                            deadline_next = sum;
                    end
                end
                default:
                begin
                    if (expired)
                    begin
                        if (periodic_reg)
                            deadline_next = sum;
                        else
                            valid_next = 1'b0;
                    end
                end
            endcase
        end
        if (ins_here)
        begin
            valid_next    = 1'b1;
            event_next    = item.event_id;
            periodic_next = item.periodic;
            period_next   = item.delay_ms;
            deadline_next = sum;
        end
    end

    always_comb
    begin
        carry_next = carry_reg;
        if (!hold)
        begin
            carry_next.go         = carry_in.go;
            carry_next.matched    = carry_in.matched | ((item.op == OP_SET) & hit);
            carry_next.free_found = carry_in.free_found | ~valid_reg;
            carry_next.free_idx   = carry_in.free_found ? carry_in.free_idx : cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            carry_reg <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        event_reg    <= event_next;
        periodic_reg <= periodic_next;
        period_reg   <= period_next;
        deadline_reg <= deadline_next;
    end

    assign carry_out = carry_reg;

endmodule

/* hdl/multi_slot_alarm_table.sv */
// Top level of the multi-slot alarm table: a row of msat_cell slots walked by a token.
// Depends on msat_pkg and msat_cell.
//
// The table holds SLOTS alarm slots (8 by default), each in its own cell. An accepted
// transaction is latched and a token walks the row one cell per cycle while the walk is
// not stalled: it is launched, passes each cell in turn, and a final step commits a new
// alarm or closes the tick. in_ready is low while an item is in flight, so no new
// transaction is taken before the last one is through. A set item updates or cancels
// every matching slot as the token passes it and records the first free slot; if nothing
// matched, the alarm is written into that slot in the final step, or dropped when the
// table is full. A tick item reports each expired slot as the token passes it. One
// report is held back in a pending register until the next report or the end of the walk
// shows whether it is the last of the tick. The walk stalls only when a report must move
// to the output register while that register still holds a result that has not been
// taken. Times compare as plain unsigned values and new deadlines wrap modulo 2^32.
module multi_slot_alarm_table
    import msat_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    op,
    input  logic [EVENT_W-1:0]      event_id,
    input  logic                    periodic,
    input  logic [PERIOD_W-1:0]     delay_ms,
    input  logic [TIME_W-1:0]       now_ms,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [EVENT_W-1:0]      fired_event,
    output logic [FIRED_SLOT_W-1:0] fired_slot,
    output logic                    last
);

    // Item and walk control
    item_t  item_reg, item_next;
    logic   busy_reg, busy_next;
    logic   start_reg, start_next;

    // Pending report, waiting to learn whether it is the last one
    logic                pend_valid_reg, pend_valid_next;
    logic [EVENT_W-1:0]  pend_event_reg, pend_event_next;
    logic [IDX_W-1:0]    pend_slot_reg, pend_slot_next;

    // Output register
    logic                    out_valid_reg, out_valid_next;
    logic [EVENT_W-1:0]      out_event_reg, out_event_next;
    logic [FIRED_SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic                    out_last_reg, out_last_next;

    carry_t chain [SLOTS+1];
    fire_t  fires [SLOTS];
    ins_t   ins;

    logic               accept;
    logic               done;
    logic               hold;
    logic               out_free;
    logic               fire_any;
    logic [EVENT_W-1:0] fire_event;
    logic [IDX_W-1:0]   fire_slot;

    assign in_ready = ~busy_reg;
    assign accept   = in_valid & ~busy_reg;

    // Token enters the first cell in the cycle after the transaction is taken
    assign chain[0] = '{go: start_reg, matched: 1'b0, free_found: 1'b0, free_idx: '0};

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            msat_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cell_idx  (IDX_W'(gi)),
                .item      (item_reg),
                .hold      (hold),
                .carry_in  (chain[gi]),
                .ins       (ins),
                .carry_out (chain[gi+1]),
                .fire      (fires[gi])
            );
        end
    endgenerate

    // Only the cell holding the token can report, so OR the reports together
    always_comb
    begin
        fire_any   = 1'b0;
        fire_event = '0;
        fire_slot  = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            fire_any   = fire_any | fires[i].fire;
            fire_event = fire_event | (fires[i].event_id & {EVENT_W{fires[i].fire}});
            fire_slot  = fire_slot | (IDX_W'(i) & {IDX_W{fires[i].fire}});
        end
    end

    // Token has left the last cell: commit or close the item
    assign done     = chain[SLOTS].go;
    assign out_free = ~out_valid_reg | out_ready;

    // Stall the walk when a held report has nowhere to go
    assign hold = pend_valid_reg & ~out_free & (fire_any | done);

    // Write a new alarm into the first free slot when nothing matched
    assign ins.en  = done & ~hold & (item_reg.op == OP_SET) & ~chain[SLOTS].matched
                   & chain[SLOTS].free_found;
    assign ins.idx = chain[SLOTS].free_idx;

    always_comb
    begin
        item_next       = item_reg;
        busy_next       = busy_reg;
        start_next      = start_reg & hold;
        pend_valid_next = pend_valid_reg;
        pend_event_next = pend_event_reg;
        pend_slot_next  = pend_slot_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        out_event_next  = out_event_reg;
        out_slot_next   = out_slot_reg;
        out_last_next   = out_last_reg;

        if (accept)
        begin
            item_next  = '{op: op_t'(op), event_id: event_id, periodic: periodic,
                           delay_ms: delay_ms, now_ms: now_ms};
            busy_next  = 1'b1;
            start_next = 1'b1;
        end

        if (!hold)
        begin
            if (fire_any)
            begin
                // A newer report exists, so the held one is not the last
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = pend_event_reg;
                    out_slot_next  = pend_slot_reg[FIRED_SLOT_W-1:0];
                    out_last_next  = 1'b0;
                end
                pend_valid_next = 1'b1;
                pend_event_next = fire_event;
                pend_slot_next  = fire_slot;
            end
            else if (done)
            begin
                // End of the walk: release the held report as the last one
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_event_next = pend_event_reg;
                    out_slot_next  = pend_slot_reg[FIRED_SLOT_W-1:0];
                    out_last_next  = 1'b1;
                end
                pend_valid_next = 1'b0;
                busy_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            start_reg      <= start_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        pend_event_reg <= pend_event_next;
        pend_slot_reg  <= pend_slot_next;
        out_event_reg  <= out_event_next;
        out_slot_reg   <= out_slot_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign fired_event = out_event_reg;
    assign fired_slot  = out_slot_reg;
    assign last        = out_last_reg;

endmodule

/* tb/multi_slot_alarm_table_tb.sv */
// Self-checking testbench for multi_slot_alarm_table: directed and random set/tick traffic
// with random stalls on both handshakes, checked against an in-bench alarm table predictor.
// Depends on msat_pkg and the multi_slot_alarm_table RTL.
`timescale 1ns / 1ps

module multi_slot_alarm_table_tb;
    import msat_pkg::*;

    // Worst run: ~310 items, each up to 8 expiries held off by the longest output stall,
    // plus the walk and the longest input gap. This limit is several times that figure.
    localparam int CYCLE_LIMIT  = 600000;
    // Drain time after the last expectation is met: a full walk plus output slack
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_ITEMS = 286;

    typedef struct packed {
        logic [EVENT_W-1:0]      ev;
        logic [FIRED_SLOT_W-1:0] slot;
        logic                    last;
    } expiry_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic                    op        = 1'b0;
    logic [EVENT_W-1:0]      event_id  = '0;
    logic                    periodic  = 1'b0;
    logic [PERIOD_W-1:0]     delay_ms  = '0;
    logic [TIME_W-1:0]       now_ms    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [EVENT_W-1:0]      fired_event;
    logic [FIRED_SLOT_W-1:0] fired_slot;
    logic                    last;

    // Predicted alarm table
    logic                alarm_valid    [SLOTS];
    logic [EVENT_W-1:0]  alarm_event    [SLOTS];
    logic                alarm_periodic [SLOTS];
    logic [PERIOD_W-1:0] alarm_period   [SLOTS];
    logic [TIME_W-1:0]   alarm_deadline [SLOTS];

    item_t   pending_items [$];
    expiry_t expected_expiries [$];
    item_t   cur_item;

    int n_items      = 0;
    int n_accepted   = 0;
    int mismatches   = 0;
    int cycle_count  = 0;
    int in_idle_left = 0;
    int in_calm_left = 0;
    int rdy_hold     = 0;
    int rdy_calm     = 0;

    multi_slot_alarm_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .event_id    (event_id),
        .periodic    (periodic),
        .delay_ms    (delay_ms),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fired_event (fired_event),
        .fired_slot  (fired_slot),
        .last        (last)
    );

    always #1 clk = ~clk;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            alarm_valid[i] = 1'b0;
        end
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        $display("[cycle %0d] %s", cycle_count, msg);
        mismatches++;
    endtask

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Advance the predicted table by one accepted transaction; queue any expiries it causes
    task automatic apply_alarm_item(input item_t it);
        logic    hit;
        expiry_t fires [$];
        expiry_t e;
        hit = 1'b0;
        if (it.op == OP_SET)
        begin
            // Update or cancel every live slot carrying this id
            for (int i = 0; i < SLOTS; i++)
            begin
                if (alarm_valid[i] && alarm_event[i] == it.event_id)
                begin
                    hit = 1'b1;
                    if (it.delay_ms == '0)
                        alarm_valid[i] = 1'b0;
                    else
                        alarm_deadline[i] = it.now_ms + TIME_W'(it.delay_ms);
                end
            end
            // No match: take the first free slot, or drop when full
            if (!hit)
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!hit && !alarm_valid[i])
                    begin
                        hit               = 1'b1;
                        alarm_valid[i]    = 1'b1;
                        alarm_event[i]    = it.event_id;
                        alarm_periodic[i] = it.periodic;
                        alarm_period[i]   = it.delay_ms;
                        alarm_deadline[i] = it.now_ms + TIME_W'(it.delay_ms);
                    end
                end
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (alarm_valid[i] && it.now_ms >= alarm_deadline[i])
                begin
                    e.ev   = alarm_event[i];
                    e.slot = FIRED_SLOT_W'(i);
                    e.last = 1'b0;
                    fires.push_back(e);
                    if (alarm_periodic[i])
                        alarm_deadline[i] = it.now_ms + TIME_W'(alarm_period[i]);
                    else
                        alarm_valid[i] = 1'b0;
                end
            end
            if (fires.size() > 0)
                fires[fires.size()-1].last = 1'b1;
            foreach (fires[j])
                expected_expiries.push_back(fires[j]);
        end
    endtask

    task automatic add_set(input logic [EVENT_W-1:0] id, input logic per,
                           input logic [PERIOD_W-1:0] dly, input logic [TIME_W-1:0] t);
        item_t it;
        it.op       = OP_SET;
        it.event_id = id;
        it.periodic = per;
        it.delay_ms = dly;
        it.now_ms   = t;
        pending_items.push_back(it);
        n_items++;
    endtask

    task automatic add_tick(input logic [TIME_W-1:0] t);
        item_t it;
        it.op       = OP_TICK;
        it.event_id = EVENT_W'($urandom);
        it.periodic = 1'($urandom);
        it.delay_ms = PERIOD_W'($urandom);
        it.now_ms   = t;
        pending_items.push_back(it);
        n_items++;
    endtask

    // Reset: hold low, then release on a rising edge
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Timeout guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Driver: present queued items, hold each until accepted, idle at random between them.
    // The predictor advances at the edge that accepts the transaction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                apply_alarm_item(cur_item);
                n_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_idle_left > 0)
                begin
                    in_idle_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    cur_item = pending_items.pop_front();
                    op       <= cur_item.op;
                    event_id <= cur_item.event_id;
                    periodic <= cur_item.periodic;
                    delay_ms <= cur_item.delay_ms;
                    now_ms   <= cur_item.now_ms;
                    in_valid <= 1'b1;
                    // Every so often run a stretch of back-to-back transactions
                    if (in_calm_left > 0)
                    begin
                        in_calm_left--;
                        in_idle_left = 0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 39) == 0)
                            in_calm_left = $urandom_range(20, 50);
                        in_idle_left = pick_gap();
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted expiry with the oldest prediction, and stall out_ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_expiries.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected expiry event=%0h slot=%0d last=%0b",
                                              fired_event, fired_slot, last));
                end
                else
                begin
                    expiry_t exp_e;
                    exp_e = expected_expiries.pop_front();
                    if (fired_event !== exp_e.ev || fired_slot !== exp_e.slot ||
                        last !== exp_e.last)
                        report_mismatch($sformatf(
                            "expiry got event=%0h slot=%0d last=%0b, want %0h/%0d/%0b",
                            fired_event, fired_slot, last, exp_e.ev, exp_e.slot, exp_e.last));
                end
            end
            if (rdy_hold > 0)
            begin
                rdy_hold--;
            end
            else if (out_ready)
            begin
                int g;
                if (rdy_calm > 0)
                begin
                    rdy_calm--;
                    g = 0;
                end
                else
                begin
                    if ($urandom_range(0, 39) == 0)
                        rdy_calm = $urandom_range(20, 60);
                    g = pick_gap();
                end
                if (g > 0)
                begin
                    out_ready <= 1'b0;
                    rdy_hold = g - 1;
                end
                else
                begin
                    rdy_hold = $urandom_range(0, 4);
                end
            end
            else
            begin
                out_ready <= 1'b1;
                rdy_hold = $urandom_range(0, 6);
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        logic [TIME_W-1:0]   tb_now;
        logic [EVENT_W-1:0]  id_salt;
        logic [PERIOD_W-1:0] dly;
        int                  r;

        // Empty table: tick reports nothing
        add_tick(32'h0000_0000);
        // New one-shot alarm with zero delay lands at deadline now
        add_set(8'h00, 1'b0, 23'h000000, 32'h0000_0000);
        // Largest delay at the latest time: deadline wraps
        add_set(8'hFF, 1'b1, 23'h7FFFFF, 32'hFFFF_FFFF);
        // Periodic alarm with zero period re-arms at the tick's own time each time it fires
        add_set(8'h10, 1'b1, 23'h000000, 32'h0000_0005);
        add_set(8'h21, 1'b0, 23'h00000A, 32'h0000_000A);
        add_set(8'h22, 1'b1, 23'h000014, 32'h0000_000A);
        add_set(8'h23, 1'b0, 23'h00001E, 32'h0000_000A);
        add_set(8'h24, 1'b1, 23'h000028, 32'h0000_000A);
        add_set(8'h25, 1'b0, 23'h000032, 32'h0000_000A);
        // Table now full: this new alarm is dropped
        add_set(8'h30, 1'b1, 23'h000005, 32'h0000_000A);
        // Nothing due yet except the zero-delay slots
        add_tick(32'h0000_0006);
        // Latest time: every live slot expires in one tick
        add_tick(32'hFFFF_FFFF);
        add_tick(32'h0000_0001);
        // Update a periodic match: deadline moves, period kept
        add_set(8'h22, 1'b0, 23'h000064, 32'h0000_0010);
        // Cancel a match
        add_set(8'h24, 1'b1, 23'h000000, 32'h0000_0010);
        // Cancel of an id that is not there places a zero-delay alarm
        add_set(8'h55, 1'b1, 23'h000000, 32'h0000_0020);
        add_tick(32'h0000_0020);
        add_tick(32'h0000_0020);
        add_set(8'hAA, 1'b0, 23'h400000, 32'h8000_0000);
        add_tick(32'h0000_0080);
        add_tick(32'h8040_0000);
        add_set(8'h10, 1'b0, 23'h000000, 32'h8040_0000);
        add_set(8'h55, 1'b0, 23'h000000, 32'h8040_0000);
        add_tick(32'hFFFF_FFFF);

        // Random part: mostly ordered time with a small pool of ids, the rest noise
        tb_now  = 32'd1000;
        id_salt = EVENT_W'($urandom);
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 50 == 49)
                id_salt = EVENT_W'($urandom);
            // Jump close to the top of the time range halfway through
            if (k == RANDOM_ITEMS / 2)
                tb_now = 32'hFFFF_FE00 + TIME_W'($urandom_range(0, 255));
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_tick(TIME_W'($urandom));
                else
                    add_set(EVENT_W'($urandom), 1'($urandom), PERIOD_W'($urandom),
                            TIME_W'($urandom));
            end
            else if (r < 52)
            begin
                tb_now = tb_now + TIME_W'($urandom_range(0, 120));
                add_tick(tb_now);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    dly = '0;
                else if (r < 85)
                    dly = PERIOD_W'($urandom_range(1, 150));
                else
                    dly = PERIOD_W'($urandom);
                add_set(id_salt ^ EVENT_W'($urandom_range(0, 11)), 1'($urandom), dly, tb_now);
            end
        end

        // Wait for every item to be taken and every expiry to arrive, then drain
        @(posedge clk);
        while (n_accepted < n_items || expected_expiries.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_expiries.size() > 0)
            report_mismatch($sformatf("%0d expiries never arrived", expected_expiries.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
hdl/msat_pkg.sv
hdl/msat_cell.sv
hdl/multi_slot_alarm_table.sv
tb/multi_slot_alarm_table_tb.sv
